// ----- rtl/xbrr_pkg.sv -----
// Package: constants and types shared by the bounded random range block.
`default_nettype none
package xbrr_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned WordW = 64;
  localparam logic [63:0] GoldenStep  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SeedXorMask = 64'hDEADBEEFDEADBEEF;
  localparam logic [63:0] NonzeroFill = 64'hDEADC0DEFEEDBEEF;
  localparam logic [63:0] MixMulA     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB     = 64'h94D049BB133111EB;
  localparam logic [0:0]  RegSeed     = 1'b0;

  // Divider control between sequencer and shared remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/xbrr_if.sv -----
// Interfaces: valid/ready channels for requests and results.
`default_nettype none
interface xbrr_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_min;
  logic [31:0] range_max;
  modport source (output valid, range_min, range_max, input ready);
  modport sink (input valid, range_min, range_max, output ready);
endinterface

interface xbrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;
  modport source (output valid, random_value, input ready);
  modport sink (input valid, random_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/xoshiro_bounded_random_range.sv -----
// Top level: bounded uniform random values from a xoshiro256++ generator.
`default_nettype none
// Usage: present a request (range_min, range_max) on req; one result beat
// comes back on rsp with random_value in range_min .. range_max-1, or
// range_min when range_max <= range_min (generator untouched).
// Seed via APB register 0 (64-bit, any address with paddr[3] low); a
// write clears the seeded flag so the next non-empty request expands the
// seed with splitmix64 (per word: the add and xor-shift, two multiplies
// built from 32x32 partial products on one shared multiplier, and a store
// of the word; then the all-zero check). Each request then takes a
// remainder for the threshold, one generator step per draw until a draw
// passes the threshold, and another remainder for the final reduction.
// Empty ranges skip the generator and the shared restoring divider.
// req.ready is low while a request is at work or a result waits; a stalled
// receiver holds the result in the output register. Reset clears the state
// to zero, the seed to zero and the seeded flag.
module xoshiro_bounded_random_range (
  input  wire         clk_i,
  input  wire         rst_ni,
  xbrr_req_if.sink    req,
  xbrr_rsp_if.source  rsp,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_MIXA, S_MUL, S_FILL, S_THR, S_THRW, S_DRAW,
    S_MOD, S_MODW, S_OUT
  } state_e;

  state_e      state_q;
  logic [63:0] seed_q;
  logic        seeded_q;
  logic [63:0] w_q [4];
  logic [31:0] lo_q, span_q, thr_q, v_q, res_q;
  logic        rvalid_q;
  logic [1:0]  widx_q;
  logic        mstep_q;   // first or second multiply of the finalizer
  logic [1:0]  pp_q;      // partial product index
  logic [63:0] z_q, mop_q, macc_q;
  xbrr_pkg::div_req_t dreq;
  xbrr_pkg::div_rsp_t drsp;

  logic        cfg_wr;
  logic [63:0] mix_in, out_w;
  logic [63:0] t0, t1, t2, t3;
  logic [31:0] pa, pb;
  logic [63:0] pprod, pshift;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3] == xbrr_pkg::RegSeed);
  assign prdata = (paddr[3] == xbrr_pkg::RegSeed) ? seed_q : '0;

  xbrr_rem u_rem (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Seed derivation for the word now being expanded.
  always_comb begin
    case (widx_q)
      2'd0:    mix_in = seed_q;
      2'd1:    mix_in = seed_q ^ xbrr_pkg::SeedXorMask;
      2'd2:    mix_in = seed_q + xbrr_pkg::GoldenStep;
      default: mix_in = ~seed_q;
    endcase
  end

  // One 32x32 partial product a cycle; low 64 bits of z * mop.
  always_comb begin
    case (pp_q)
      2'd0:    begin pa = z_q[31:0];  pb = mop_q[31:0];  end
      2'd1:    begin pa = z_q[63:32]; pb = mop_q[31:0];  end
      2'd2:    begin pa = z_q[31:0];  pb = mop_q[63:32]; end
      default: begin pa = z_q[63:32]; pb = 32'd0;        end
    endcase
    pprod  = {32'd0, pa} * {32'd0, pb};
    pshift = (pp_q == 2'd0) ? pprod : {pprod[31:0], 32'd0};
  end

  always_comb begin
    out_w = w_q[0] + w_q[3];
    out_w = {out_w[40:0], out_w[63:41]} + w_q[0];
    t2 = w_q[2] ^ w_q[0];
    t3 = w_q[3] ^ w_q[1];
    t1 = w_q[1] ^ t2;
    t0 = w_q[0] ^ t3;
    t2 = t2 ^ {w_q[1][46:0], 17'd0};
    t3 = {t3[18:0], t3[63:19]};
  end

  always_comb begin
    dreq.start    = (state_q == S_THR) || (state_q == S_MOD);
    dreq.dividend = (state_q == S_THR) ? (32'd0 - span_q) : v_q;
    dreq.divisor  = span_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      seed_q   <= '0;
      seeded_q <= 1'b0;
      rvalid_q <= 1'b0;
      widx_q   <= '0;
      mstep_q  <= 1'b0;
      pp_q     <= '0;
      for (int i = 0; i < 4; i++) w_q[i] <= '0;
    end else begin
      if (cfg_wr) begin
        seed_q   <= pwdata;
        seeded_q <= 1'b0;
      end
      if (rvalid_q && rsp.ready) rvalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && !rvalid_q) begin
            lo_q   <= req.range_min;
            span_q <= req.range_max - req.range_min;
            if (req.range_max <= req.range_min) begin
              res_q   <= req.range_min;
              state_q <= S_OUT;
            end else begin
              widx_q  <= 2'd0;
              state_q <= seeded_q ? S_THR : S_MIXA;
            end
          end
        end
        S_MIXA: begin
          // add the golden step, xor-shift 30, then first multiply
          z_q     <= (mix_in + xbrr_pkg::GoldenStep)
                   ^ ((mix_in + xbrr_pkg::GoldenStep) >> 30);
          mop_q   <= xbrr_pkg::MixMulA;
          macc_q  <= '0;
          pp_q    <= 2'd0;
          mstep_q <= 1'b0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          pp_q <= pp_q + 2'd1;
          if (pp_q == 2'd3) begin
            if (!mstep_q) begin
              z_q     <= macc_q ^ (macc_q >> 27);
              mop_q   <= xbrr_pkg::MixMulB;
              macc_q  <= '0;
              mstep_q <= 1'b1;
            end else begin
              z_q     <= macc_q ^ (macc_q >> 31);
              state_q <= S_FILL;
            end
          end else begin
            macc_q <= macc_q + pshift;
          end
        end
        S_FILL: begin
          w_q[widx_q] <= z_q;
          widx_q      <= widx_q + 2'd1;
          if (widx_q == 2'd3) begin
            seeded_q <= 1'b1;
            state_q  <= S_SEED;
          end else begin
            state_q <= S_MIXA;
          end
        end
        S_SEED: begin
          // force a nonzero state
          if ((w_q[0] | w_q[1] | w_q[2] | w_q[3]) == '0) w_q[0] <= xbrr_pkg::NonzeroFill;
          state_q <= S_THR;
        end
        S_THR: state_q <= S_THRW;
        S_THRW: begin
          if (drsp.done) begin
            thr_q   <= drsp.remainder;
            state_q <= S_DRAW;
          end
        end
        S_DRAW: begin
          // advance once; reject draws below the threshold
          w_q[0] <= t0;
          w_q[1] <= t1;
          w_q[2] <= t2;
          w_q[3] <= t3;
          v_q    <= out_w[63:32];
          if (out_w[63:32] >= thr_q) state_q <= S_MOD;
        end
        S_MOD: state_q <= S_MODW;
        S_MODW: begin
          if (drsp.done) begin
            res_q   <= lo_q + drsp.remainder;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          rvalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state_q == S_IDLE) && !rvalid_q;
  assign rsp.valid        = rvalid_q;
  assign rsp.random_value = res_q;

  // Stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.random_value))
    else $error("result changed while stalled");
  // No new request while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("ready while result pending");
  // Divider starts only from a waiting-free state.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |=> state_q == S_THRW || state_q == S_MODW)
    else $error("divider start out of sequence");
  // A result lies in range for non-empty requests.
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MODW && drsp.done |-> drsp.remainder < span_q)
    else $error("remainder out of range");
endmodule
`default_nettype wire

// ----- rtl/xbrr_rem.sv -----
// Shared remainder unit: restoring division, one quotient bit per cycle.
`default_nettype none
module xbrr_rem (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  xbrr_pkg::div_req_t req_i,
  output xbrr_pkg::div_rsp_t rsp_o
);
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d, dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], dvd_q[31]} - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = trial[32] ? {rem_q[31:0], dvd_q[31]} : trial;
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q[31:0];
endmodule
`default_nettype wire

// ----- bench/xoshiro_bounded_random_range_tb.sv -----
// Testbench: bounded random range block checked beat by beat against a local generator model.
`timescale 1ns / 1ps
module xoshiro_bounded_random_range_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  xbrr_req_if req_ch ();
  xbrr_rsp_if rsp_ch ();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.range_min = '0;
    req_ch.range_max = '0;
    rsp_ch.ready = 1'b0;
  end

  xoshiro_bounded_random_range uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the generator: four state words, seeded flag and seed register.
  logic [63:0] gen_words [4];
  logic        gen_seeded;
  logic [63:0] seed_reg;

  logic [31:0] pending_values [$];
  int unsigned error_count = 0;
  int unsigned beats_checked = 0;
  int unsigned empty_requests = 0;
  int unsigned seeds_written = 0;
  int          idle_phase = 0;   // 0: sender 38/rcv 50, 1: sender 50/rcv 38, 2: no idling
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  function automatic logic [63:0] splitmix(input logic [63:0] x);
    logic [63:0] z;
    z = x + xbrr_pkg::GoldenStep;
    z = (z ^ (z >> 30)) * xbrr_pkg::MixMulA;
    z = (z ^ (z >> 27)) * xbrr_pkg::MixMulB;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] next_word();
    logic [63:0] w0, w1, w2, w3, res, t;
    w0 = gen_words[0]; w1 = gen_words[1]; w2 = gen_words[2]; w3 = gen_words[3];
    res = rotl64(w0 + w3, 23) + w0;
    t = w1 << 17;
    w2 ^= w0;
    w3 ^= w1;
    w1 ^= w2;
    w0 ^= w3;
    w2 ^= t;
    w3 = rotl64(w3, 45);
    gen_words[0] = w0; gen_words[1] = w1; gen_words[2] = w2; gen_words[3] = w3;
    return res;
  endfunction

  // Work out the value for one request and advance the local generator.
  function automatic logic [31:0] predict_draw(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] span, thresh, v;
    logic [63:0] draw_word;
    if (hi <= lo) return lo;
    if (!gen_seeded) begin
      gen_words[0] = splitmix(seed_reg);
      gen_words[1] = splitmix(seed_reg ^ xbrr_pkg::SeedXorMask);
      gen_words[2] = splitmix(seed_reg + xbrr_pkg::GoldenStep);
      gen_words[3] = splitmix(~seed_reg);
      if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == '0)
        gen_words[0] = xbrr_pkg::NonzeroFill;
      gen_seeded = 1'b1;
    end
    span = hi - lo;
    thresh = (32'd0 - span) % span;
    do begin
      draw_word = next_word();
      v = draw_word[63:32];
    end while (v < thresh);
    return lo + v % span;
  endfunction

  // Receiver: check every accepted beat, then pick ready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        beats_checked++;
        if (pending_values.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat, expected none, actual %h", $time,
                   rsp_ch.random_value);
        end else begin
          logic [31:0] want;
          want = pending_values.pop_front();
          if (rsp_ch.random_value !== want) begin
            error_count++;
            $display("%0t: random_value mismatch, expected %h, actual %h", $time, want,
                     rsp_ch.random_value);
          end
        end
      end
      // Long hold-off: block the output so the block fills up and drops req.ready.
      if (hold_request && !hold_done && hold_left == 0) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (idle_phase)
          0: rsp_ch.ready <= ($urandom_range(99) >= 50);
          1: rsp_ch.ready <= ($urandom_range(99) >= 38);
          default: rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 4'd0) begin
      seed_reg = data;
      gen_seeded = 1'b0;
      seeds_written++;
    end
    @(posedge clk_i);
  endtask

  task automatic apb_check_seed();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= 4'd0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== seed_reg) begin
      error_count++;
      $display("%0t: seed readback mismatch, expected %h, actual %h", $time, seed_reg,
               prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one beat and hold it until accepted; the predictor runs at acceptance.
  task automatic send_request(input logic [31:0] lo, input logic [31:0] hi,
                              input bit typed, input logic [31:0] typed_val);
    logic [31:0] predicted;
    int gap_pct;
    gap_pct = (idle_phase == 0) ? 38 : (idle_phase == 1) ? 50 : 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.range_min <= lo;
    req_ch.range_max <= hi;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predicted = predict_draw(lo, hi);
    if (hi <= lo) empty_requests++;
    pending_values.push_back(typed ? typed_val : predicted);
  endtask

  // Drop valid and wait until every result is in, then give the block slack.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_request();
    logic [31:0] lo, hi;
    int pick;
    pick = $urandom_range(99);
    lo = $urandom;
    if (pick < 10) begin
      hi = lo - $urandom_range(0, 3);                 // empty range
    end else if (pick < 35) begin
      lo = $urandom_range(0, 32'hFFFF_FFF0);
      hi = lo + $urandom_range(1, 16);               // tiny spans
    end else if (pick < 50) begin
      lo = $urandom_range(0, 3);
      hi = 32'hFFFF_FFFF - $urandom_range(0, 3);     // near-full spans
    end else if (pick < 60) begin
      lo = $urandom_range(0, 32'h7FFF_FFFF);
      hi = lo + 32'h8000_0000 + $urandom_range(0, 255);  // heavy rejection
    end else begin
      hi = $urandom;
    end
    send_request(lo, hi, 1'b0, '0);
  endtask

  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
    bit          typed;
    logic [31:0] value;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},  // empty, zero
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},  // empty, all ones
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},  // max below min
    '{32'h0000_0005, 32'h0000_0003, 1'b1, 32'h0000_0005},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000},  // single value, seeds from zero
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},          // widest span
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
    '{32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0},
    '{32'h8000_0000, 32'h8000_0001, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 32'h8000_0001, 1'b0, 32'h0},          // threshold near half
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h1234_5678, 32'h1234_5678, 1'b1, 32'h1234_5678},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0000_0003, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF}
  };

  logic [63:0] seed_plan [] = '{
    64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'h0000_0000_0000_0001, 64'h0, 64'h0, 64'h0
  };

  initial begin
    gen_words = '{default: '0};
    gen_seeded = 1'b0;
    seed_reg = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run on the reset seed, with idle_phase 0 idling on both sides.
    foreach (directed_rows[i])
      send_request(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].typed,
                   directed_rows[i].value);
    drain();
    apb_check_seed();

    // Write to an unmapped address: must not disturb the seed or the generator.
    apb_write(4'd8, 64'hDEAD_0000_BEEF_0000);
    apb_check_seed();
    for (int i = 0; i < 4; i++) random_request();
    drain();

    for (int s = 0; s < seed_plan.size(); s++) begin
      logic [63:0] seed;
      seed = (s < 4) ? seed_plan[s] : {$urandom, $urandom};
      apb_write(4'd0, seed);
      apb_check_seed();
      for (int p = 0; p < 3; p++) begin
        idle_phase = p;
        for (int n = 0; n < 80; n++) begin
          if (s == 2 && p == 2 && n == 10) hold_request = 1'b1;
          random_request();
        end
      end
      drain();
      // Re-seed with the same value between two requests: the sequence restarts.
      if (s == 1) begin
        apb_write(4'd0, seed);
        for (int n = 0; n < 20; n++) random_request();
        drain();
      end
    end

    idle_phase = 2;
    drain();
    $display("covered %0d result beats (%0d empty ranges), %0d seed writes, long output stall",
             beats_checked, empty_requests, seeds_written);
    if (error_count == 0) begin
      $display("xoshiro_bounded_random_range_tb: clean");
    end else begin
      $display("xoshiro_bounded_random_range_tb: errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("xoshiro_bounded_random_range_tb: errors");
    $finish;
  end
endmodule
